>>> hdl/pfa_pkg.sv
package pfa_pkg;

    // Bytes taken by one block header.
    localparam int unsigned HDR_BYTES = 5;

    // Widths of the stream payloads.
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 24;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_COAL  = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_NO_ROOM  = 3'd2,
        ST_NO_FIT   = 3'd3,
        ST_NOT_HDR  = 3'd4,
        ST_ALREADY  = 3'd5,
        ST_NO_MERGE = 3'd6
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_RCLR = 3'd0,
        S_IDLE = 3'd1,
        S_ICLR = 3'd2,
        S_INIT = 3'd3,
        S_WALK = 3'd4,
        S_WR2  = 3'd5,
        S_DONE = 3'd6
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr;
        logic init_wr;
        logic step;
        logic wr2;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic step_done;
        logic step_two;
        logic in_init;
        logic out_full;
    } t_dp_stat;

endpackage

>>> hdl/pfa_ctrl.sv
module pfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_tvalid,
    output logic               o_in_tready,
    input  pfa_pkg::t_dp_stat  i_stat,
    output pfa_pkg::t_dp_cmd   o_cmd
);

    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;

    // State register; reset starts the clearing pass over the header store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_RCLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_RCLR: begin
                if (i_stat.clr_last) n_state = pfa_pkg::S_IDLE;
            end
            pfa_pkg::S_IDLE: begin
                if (i_in_tvalid) begin
                    n_state = i_stat.in_init ? pfa_pkg::S_ICLR : pfa_pkg::S_WALK;
                end
            end
            pfa_pkg::S_ICLR: begin
                if (i_stat.clr_last) n_state = pfa_pkg::S_INIT;
            end
            pfa_pkg::S_INIT: begin
                n_state = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_WALK: begin
                if (i_stat.step_done) begin
                    n_state = i_stat.step_two ? pfa_pkg::S_WR2 : pfa_pkg::S_DONE;
                end
            end
            pfa_pkg::S_WR2: begin
                n_state = pfa_pkg::S_DONE;
            end
            pfa_pkg::S_DONE: begin
                if (!i_stat.out_full) n_state = pfa_pkg::S_IDLE;
            end
            default: begin
                n_state = pfa_pkg::S_RCLR;
            end
        endcase
    end

    // Commands for the current state.
    always_comb begin
        o_cmd       = '0;
        o_in_tready = 1'b0;
        case (r_state)
            pfa_pkg::S_RCLR: o_cmd.clr = 1'b1;
            pfa_pkg::S_IDLE: begin
                o_in_tready = 1'b1;
                o_cmd.load  = i_in_tvalid;
            end
            pfa_pkg::S_ICLR: o_cmd.clr = 1'b1;
            pfa_pkg::S_INIT: o_cmd.init_wr = 1'b1;
            pfa_pkg::S_WALK: o_cmd.step = 1'b1;
            pfa_pkg::S_WR2:  o_cmd.wr2 = 1'b1;
            pfa_pkg::S_DONE: o_cmd.finish = !i_stat.out_full;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/pfa_dp.sv
module pfa_dp #(
    parameter int PAGE_BYTES = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfa_pkg::t_dp_cmd                    i_cmd,
    output pfa_pkg::t_dp_stat                   o_stat,
    input  logic [pfa_pkg::IN_USER_W-1:0]       i_in_tuser,
    input  logic [pfa_pkg::IN_DATA_W-1:0]       i_in_tdata,
    input  logic                                i_out_tready,
    output logic                                o_out_tvalid,
    output logic [pfa_pkg::OUT_DATA_W-1:0]      o_out_tdata
);

    // Offsets, sizes and counts all fit in CW bits; AW bits address the store.
    localparam int CW = $clog2(PAGE_BYTES + 1);
    localparam int AW = $clog2(PAGE_BYTES);
    localparam int EW = CW + 2;
    localparam int XW = ((CW > 9) ? CW : 9) + 2;

    localparam logic [XW-1:0] PAGE_X     = XW'(PAGE_BYTES);
    localparam logic [XW-1:0] HDR_X      = XW'(pfa_pkg::HDR_BYTES);
    localparam logic [CW-1:0] PAGE_C     = CW'(PAGE_BYTES);
    localparam logic [CW-1:0] HDR_C      = CW'(pfa_pkg::HDR_BYTES);
    localparam logic [CW-1:0] INIT_SIZE  = CW'(PAGE_BYTES - pfa_pkg::HDR_BYTES);
    localparam logic [CW-1:0] LAST_ENTRY = CW'(PAGE_BYTES - 1);

    // Input word fields.
    pfa_pkg::t_action in_act;
    logic [8:0]       in_req;
    logic [8:0]       in_boff;
    logic [XW-1:0]    in_boff_x;

    assign in_act    = pfa_pkg::t_action'(i_in_tuser);
    assign in_req    = i_in_tdata[8:0];
    assign in_boff   = i_in_tdata[17:9];
    assign in_boff_x = XW'(in_boff);

    // Header store: {mark, free, size} per byte offset.
    logic [EW-1:0] r_mem [0:PAGE_BYTES-1];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Item registers.
    pfa_pkg::t_action r_act;
    logic [8:0]       r_req;
    logic             r_inpage;
    logic [CW-1:0]    r_off;
    logic             r_prev_valid;
    logic             r_prev_free;
    logic [CW-1:0]    r_prev_size;
    logic [CW-1:0]    r_prev_off;
    logic [CW-1:0]    r_fc;
    logic [CW-1:0]    r_where;
    pfa_pkg::t_status r_status;
    logic [CW-1:0]    r_w2_addr;
    logic [EW-1:0]    r_w2_data;
    logic [CW-1:0]    r_clr;
    logic             r_ovalid;
    logic [pfa_pkg::OUT_DATA_W-1:0] r_odata;

    // Decode of the header at the walk position.
    logic          cur_mark;
    logic          cur_free;
    logic [CW-1:0] cur_size;
    logic [CW-1:0] nxt_off;
    logic [XW-1:0] req_x;
    logic [XW-1:0] fc_x;
    logic [XW-1:0] room_x;
    logic [XW-1:0] where_x;
    logic [CW-1:0] req_c;
    logic          too_big;
    logic          no_room;
    logic          fit_split;
    logic          fit_whole;
    logic          merge;
    logic          page_empty;

    assign cur_mark   = r_rd[EW-1] && r_inpage && (r_off < PAGE_C);
    assign cur_free   = r_rd[CW];
    assign cur_size   = r_rd[CW-1:0];
    assign nxt_off    = CW'(r_off + cur_size + HDR_C);
    assign req_x      = XW'(r_req);
    assign fc_x       = XW'(r_fc);
    assign room_x     = (r_fc >= HDR_C) ? (fc_x - HDR_X) : '0;
    assign too_big    = (req_x + HDR_X + HDR_X) > PAGE_X;
    assign no_room    = req_x > room_x;
    assign req_c      = req_x[CW-1:0];
    assign fit_split  = cur_free && (({1'b0, req_c} + {1'b0, HDR_C}) < {1'b0, cur_size});
    assign fit_whole  = cur_free && (req_c == cur_size);
    assign merge      = cur_mark && r_prev_valid && r_prev_free && cur_free;
    assign where_x    = XW'(r_where);
    assign page_empty = (r_fc == INIT_SIZE);

    // Outcome of one walk step.
    logic             st_done;
    logic             st_two;
    pfa_pkg::t_status st_status;
    logic [CW-1:0]    st_where;
    logic [CW-1:0]    st_fc;
    logic             w1_en;
    logic [CW-1:0]    w1_addr;
    logic [EW-1:0]    w1_data;
    logic [CW-1:0]    w2_addr;
    logic [EW-1:0]    w2_data;

    always_comb begin
        st_done   = 1'b0;
        st_two    = 1'b0;
        st_status = pfa_pkg::ST_OK;
        st_where  = '0;
        st_fc     = r_fc;
        w1_en     = 1'b0;
        w1_addr   = r_off;
        w1_data   = '0;
        w2_addr   = r_off;
        w2_data   = '0;
        case (r_act)
            pfa_pkg::ACT_ALLOC: begin
                if (too_big) begin
                    st_done   = 1'b1;
                    st_status = pfa_pkg::ST_TOO_BIG;
                end else if (no_room) begin
                    st_done   = 1'b1;
                    st_status = pfa_pkg::ST_NO_ROOM;
                end else if (!cur_mark) begin
                    st_done   = 1'b1;
                    st_status = pfa_pkg::ST_NO_FIT;
                end else if (fit_split) begin
                    // Used block of the request size, free remainder behind it.
                    st_done  = 1'b1;
                    st_two   = 1'b1;
                    st_where = r_off;
                    st_fc    = r_fc - req_c - HDR_C;
                    w1_en    = 1'b1;
                    w1_data  = {1'b1, 1'b0, req_c};
                    w2_addr  = CW'(r_off + req_c + HDR_C);
                    w2_data  = {1'b1, 1'b1, CW'(cur_size - req_c - HDR_C)};
                end else if (fit_whole) begin
                    st_done  = 1'b1;
                    st_where = r_off;
                    st_fc    = r_fc - req_c;
                    w1_en    = 1'b1;
                    w1_data  = {1'b1, 1'b0, cur_size};
                end
            end
            pfa_pkg::ACT_FREE: begin
                st_done = 1'b1;
                if (!cur_mark) begin
                    st_status = pfa_pkg::ST_NOT_HDR;
                end else if (cur_free) begin
                    st_status = pfa_pkg::ST_ALREADY;
                end else begin
                    st_fc   = r_fc + cur_size;
                    w1_en   = 1'b1;
                    w1_data = {1'b1, 1'b1, cur_size};
                end
            end
            pfa_pkg::ACT_COAL: begin
                if (!cur_mark) begin
                    st_done   = 1'b1;
                    st_status = pfa_pkg::ST_NO_MERGE;
                end else if (merge) begin
                    // Previous block absorbs this one and its header.
                    st_done  = 1'b1;
                    st_two   = 1'b1;
                    st_where = r_prev_off;
                    st_fc    = r_fc + HDR_C;
                    w1_en    = 1'b1;
                    w1_addr  = r_prev_off;
                    w1_data  = {1'b1, 1'b1, CW'(r_prev_size + cur_size + HDR_C)};
                    w2_addr  = r_off;
                    w2_data  = '0;
                end
            end
            default: begin
                st_done = 1'b1;
            end
        endcase
    end

    // Write port select.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = w1_addr[AW-1:0];
        mem_wdata = w1_data;
        if (i_cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr[AW-1:0];
            mem_wdata = '0;
        end else if (i_cmd.init_wr) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {1'b1, 1'b1, INIT_SIZE};
        end else if (i_cmd.step && st_done && w1_en) begin
            mem_we    = 1'b1;
            mem_waddr = w1_addr[AW-1:0];
            mem_wdata = w1_data;
        end else if (i_cmd.wr2) begin
            mem_we    = 1'b1;
            mem_waddr = r_w2_addr[AW-1:0];
            mem_wdata = r_w2_data;
        end
    end

    // Read address: chain start or freed offset on load, else the next header.
    always_comb begin
        if (i_cmd.load) begin
            mem_raddr = (in_act == pfa_pkg::ACT_FREE) ? in_boff_x[AW-1:0] : '0;
        end else begin
            mem_raddr = nxt_off[AW-1:0];
        end
    end

    // Header store access.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_fc         <= '0;
            r_prev_valid <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= (r_clr == LAST_ENTRY) ? '0 : r_clr + 1'b1;
            end
            if (i_cmd.init_wr) begin
                r_fc <= INIT_SIZE;
            end else if (i_cmd.step && st_done) begin
                r_fc <= st_fc;
            end
            if (i_cmd.load) begin
                r_prev_valid <= 1'b0;
            end else if (i_cmd.step && !st_done) begin
                r_prev_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= in_act;
            r_req    <= in_req;
            r_inpage <= (in_act != pfa_pkg::ACT_FREE) || (in_boff_x < PAGE_X);
            r_off    <= (in_act == pfa_pkg::ACT_FREE) ? in_boff_x[CW-1:0] : '0;
        end else if (i_cmd.step && !st_done) begin
            r_off <= nxt_off;
        end
        if (i_cmd.step && !st_done) begin
            r_prev_free <= cur_free;
            r_prev_size <= cur_size;
            r_prev_off  <= r_off;
        end
        if (i_cmd.step && st_done) begin
            r_status  <= st_status;
            r_where   <= st_where;
            r_w2_addr <= w2_addr;
            r_w2_data <= w2_data;
        end else if (i_cmd.init_wr) begin
            r_status <= pfa_pkg::ST_OK;
            r_where  <= '0;
        end
        if (i_cmd.finish) begin
            r_odata <= {2'b00, page_empty, fc_x[8:0], where_x[8:0], r_status};
        end
    end

    assign o_out_tvalid = r_ovalid;
    assign o_out_tdata  = r_odata;

    assign o_stat.clr_last  = (r_clr == LAST_ENTRY);
    assign o_stat.step_done = st_done;
    assign o_stat.step_two  = st_two;
    assign o_stat.in_init   = (in_act == pfa_pkg::ACT_INIT);
    assign o_stat.out_full  = r_ovalid && !i_out_tready;

endmodule

>>> hdl/page_heap_first_fit_allocator.sv
// First-fit heap allocator for one page of PAGE_BYTES bytes.
// Input stream: one word per action. tuser carries the action (init, allocate,
// free, coalesce); tdata carries the request size and the block offset.
// Output stream: exactly one word per input word, in order, with the status,
// the header offset of the allocated or merged block, the free byte count
// and the page-empty flag.
// The block serves one word at a time. Allocate and coalesce walk the header
// chain in the header store, one header per cycle, set by the single read
// port of the store. The walk takes one step per header visited and one
// more when it runs off the end of the chain; when a block is split or two
// blocks are merged, the second header is written after the walk. Free
// handles only the header at the given offset. Init clears the header
// store, one entry a cycle, and then writes the first header. Input ready
// returns in the cycle after the result is loaded.
// After reset the same clearing pass runs with tready low; the page then
// holds no headers and the free count is zero.
// A finished word waits in the output register while the receiver stalls;
// a new word is accepted meanwhile, and its result is held back until the
// waiting word has been taken.
module page_heap_first_fit_allocator #(
    parameter int PAGE_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: [8:0] request_size, [17:9] block_offset, [23:18] zero
    input  logic [23:0] i_s_axis_tdata,
    // tuser: [1:0] action
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: [2:0] status, [11:3] result_offset, [20:12] free_bytes,
    //        [21] page_empty, [23:22] zero
    output logic [23:0] o_m_axis_tdata
);

    pfa_pkg::t_dp_cmd  cmd;
    pfa_pkg::t_dp_stat stat;

    // Sequencer.
    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (i_s_axis_tvalid),
        .o_in_tready (o_s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Header store, walk arithmetic and output register.
    pfa_dp #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_tuser   (i_s_axis_tuser),
        .i_in_tdata   (i_s_axis_tdata),
        .i_out_tready (i_m_axis_tready),
        .o_out_tvalid (o_m_axis_tvalid),
        .o_out_tdata  (o_m_axis_tdata)
    );

    // The clearing pass follows reset, so no word is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready during the clearing pass");

    // One word in service at a time.
    a_one_in_service: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second word accepted while one is in service");

    // A rejected action reports offset zero.
    a_reject_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[2:0] != pfa_pkg::ST_OK))
            |-> (o_m_axis_tdata[11:3] == 9'd0))
        else $error("nonzero offset on a rejected action");

    // Only one command is issued to the datapath in a cycle.
    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

endmodule

>>> tb/page_heap_first_fit_allocator_test.sv
module page_heap_first_fit_allocator_test;

    localparam int PAGE = 512;
    localparam int HDR  = pfa_pkg::HDR_BYTES;

    // One result word as the allocator reports it.
    typedef struct {
        pfa_pkg::t_status status;
        logic [8:0]       where;
        logic [8:0]       free_bytes;
        logic             empty;
    } t_heap_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // tdata: [8:0] request_size, [17:9] block_offset, [23:18] zero
    logic [23:0] i_s_axis_tdata;
    // tuser: [1:0] action
    logic [1:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // tdata: [2:0] status, [11:3] result_offset, [20:12] free_bytes,
    //        [21] page_empty, [23:22] zero
    logic [23:0] o_m_axis_tdata;

    page_heap_first_fit_allocator #(
        .PAGE_BYTES(PAGE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow copy of the page: header marks, free marks and block sizes.
    bit heap_mark [0:PAGE-1];
    bit heap_free [0:PAGE-1];
    int heap_size [0:PAGE-1];
    int heap_free_count;

    t_heap_result pending_results[$];

    int n_errors;
    int n_checked;
    int n_sent;
    int action_seen [0:3];
    int status_seen [0:7];
    bit calm;

    always #4 i_clk = ~i_clk;

    function automatic bit is_hdr(int off);
        return off < PAGE && heap_mark[off];
    endfunction

    function automatic void set_hdr(int off, bit is_free, int size);
        heap_mark[off] = 1'b1;
        heap_free[off] = is_free;
        heap_size[off] = size;
    endfunction

    // Apply one action to the shadow page and return the word it should produce.
    function automatic t_heap_result heap_apply(pfa_pkg::t_action act, int req, int boff);
        t_heap_result r;
        int off;
        int nxt;
        int sz;
        int room;
        bit done;
        r.status = pfa_pkg::ST_OK;
        r.where  = '0;
        case (act)
            pfa_pkg::ACT_INIT: begin
                for (int i = 0; i < PAGE; i++) begin
                    heap_mark[i] = 1'b0;
                    heap_free[i] = 1'b0;
                    heap_size[i] = 0;
                end
                set_hdr(0, 1'b1, PAGE - HDR);
                heap_free_count = PAGE - HDR;
            end
            pfa_pkg::ACT_ALLOC: begin
                room = heap_free_count >= HDR ? heap_free_count - HDR : 0;
                if (req + 10 > PAGE) begin
                    r.status = pfa_pkg::ST_TOO_BIG;
                end else if (req > room) begin
                    r.status = pfa_pkg::ST_NO_ROOM;
                end else begin
                    // First fit: split when there is room for a header, or take it whole.
                    r.status = pfa_pkg::ST_NO_FIT;
                    off = 0;
                    done = 1'b0;
                    while (!done && is_hdr(off)) begin
                        sz = heap_size[off];
                        if (heap_free[off] && req + HDR < sz) begin
                            nxt = off + req + HDR;
                            set_hdr(off, 1'b0, req);
                            set_hdr(nxt, 1'b1, sz - req - HDR);
                            heap_free_count -= req + HDR;
                            r.status = pfa_pkg::ST_OK;
                            r.where = off[8:0];
                            done = 1'b1;
                        end else if (heap_free[off] && req == sz) begin
                            heap_free[off] = 1'b0;
                            heap_free_count -= req;
                            r.status = pfa_pkg::ST_OK;
                            r.where = off[8:0];
                            done = 1'b1;
                        end else begin
                            off = off + sz + HDR;
                        end
                    end
                end
            end
            pfa_pkg::ACT_FREE: begin
                if (!is_hdr(boff)) begin
                    r.status = pfa_pkg::ST_NOT_HDR;
                end else if (heap_free[boff]) begin
                    r.status = pfa_pkg::ST_ALREADY;
                end else begin
                    heap_free[boff] = 1'b1;
                    heap_free_count += heap_size[boff];
                end
            end
            default: begin
                // Merge the first pair of neighboring free blocks.
                r.status = pfa_pkg::ST_NO_MERGE;
                off = 0;
                done = 1'b0;
                while (!done && is_hdr(off)) begin
                    nxt = off + heap_size[off] + HDR;
                    if (heap_free[off] && is_hdr(nxt) && heap_free[nxt]) begin
                        heap_size[off] = heap_size[off] + heap_size[nxt] + HDR;
                        heap_mark[nxt] = 1'b0;
                        heap_free[nxt] = 1'b0;
                        heap_size[nxt] = 0;
                        heap_free_count += HDR;
                        r.status = pfa_pkg::ST_OK;
                        r.where = off[8:0];
                        done = 1'b1;
                    end else begin
                        off = nxt;
                    end
                end
            end
        endcase
        r.free_bytes = heap_free_count[8:0];
        r.empty = (heap_free_count == PAGE - HDR);
        return r;
    endfunction

    // Pick an allocate size: mostly small, often an exact or just-too-small fit.
    function automatic int choose_alloc_size();
        int sizes[$];
        int off;
        int p;
        int pick;
        off = 0;
        while (is_hdr(off)) begin
            if (heap_free[off]) sizes.push_back(heap_size[off]);
            off = off + heap_size[off] + HDR;
        end
        p = $urandom_range(0, 99);
        if (p < 55 || sizes.size() == 0) return $urandom_range(0, 40);
        pick = sizes[$urandom_range(0, sizes.size() - 1)];
        if (p < 72) return pick;
        if (p < 85) return pick > 4 ? pick - $urandom_range(1, 4) : 0;
        return $urandom_range(0, 511);
    endfunction

    // Pick a block to free: mostly a used header, sometimes any offset at all.
    function automatic int choose_free_offset();
        int used[$];
        int all[$];
        int off;
        int p;
        off = 0;
        while (is_hdr(off)) begin
            all.push_back(off);
            if (!heap_free[off]) used.push_back(off);
            off = off + heap_size[off] + HDR;
        end
        p = $urandom_range(0, 99);
        if (p < 70 && used.size() != 0) return used[$urandom_range(0, used.size() - 1)];
        if (p < 80 && all.size() != 0) return all[$urandom_range(0, all.size() - 1)];
        return $urandom_range(0, 511);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Send one word; called and returning at a falling edge.
    task automatic send_word(pfa_pkg::t_action act, int req, int boff);
        logic [8:0] req9;
        logic [8:0] off9;
        req9 = req[8:0];
        off9 = boff[8:0];
        if (!calm && $urandom_range(0, 99) < 34) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {6'd0, off9, req9};
        i_s_axis_tuser  = act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(heap_apply(act, req9, off9));
        action_seen[act]++;
        n_sent++;
        @(negedge i_clk);
    endtask

    // Receiver side: random backpressure unless in a calm stretch.
    always @(negedge i_clk) begin
        if (calm) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= ($urandom_range(0, 99) >= 34);
    end

    // Compare every output word with the oldest expected one.
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_checked++;
            status_seen[o_m_axis_tdata[2:0]]++;
            if (pending_results.size() == 0) begin
                report_mismatch("output word with none expected", o_m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", o_m_axis_tdata[2:0], want.status);
                if (o_m_axis_tdata[11:3] != want.where)
                    report_mismatch("result_offset", o_m_axis_tdata[11:3], want.where);
                if (o_m_axis_tdata[20:12] != want.free_bytes)
                    report_mismatch("free_bytes", o_m_axis_tdata[20:12], want.free_bytes);
                if (o_m_axis_tdata[21] != want.empty)
                    report_mismatch("page_empty", o_m_axis_tdata[21], want.empty);
            end
        end
    end

    // Allocate, free and coalesce on a page that was never set up.
    task automatic test_before_init();
        send_word(pfa_pkg::ACT_ALLOC, 503, $urandom_range(0, 511));
        send_word(pfa_pkg::ACT_ALLOC, 502, $urandom_range(0, 511));
        send_word(pfa_pkg::ACT_ALLOC, 0, $urandom_range(0, 511));
        send_word(pfa_pkg::ACT_FREE, $urandom_range(0, 511), 0);
        send_word(pfa_pkg::ACT_COAL, $urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    // Split, exact fit, near miss, double free, bad offsets and merges.
    task automatic test_directed_actions();
        send_word(pfa_pkg::ACT_INIT, 511, 511);
        send_word(pfa_pkg::ACT_ALLOC, 503, 0);
        send_word(pfa_pkg::ACT_ALLOC, 502, 0);
        send_word(pfa_pkg::ACT_ALLOC, 0, 0);
        send_word(pfa_pkg::ACT_ALLOC, 100, 0);
        send_word(pfa_pkg::ACT_ALLOC, 50, 0);
        send_word(pfa_pkg::ACT_FREE, 0, 5);
        send_word(pfa_pkg::ACT_FREE, 0, 5);
        send_word(pfa_pkg::ACT_FREE, 0, 7);
        send_word(pfa_pkg::ACT_FREE, 0, 511);
        send_word(pfa_pkg::ACT_ALLOC, 100, 0);
        send_word(pfa_pkg::ACT_FREE, 511, 110);
        send_word(pfa_pkg::ACT_FREE, 0, 5);
        send_word(pfa_pkg::ACT_COAL, 0, 0);
        send_word(pfa_pkg::ACT_COAL, 511, 511);
        send_word(pfa_pkg::ACT_COAL, 0, 0);
        send_word(pfa_pkg::ACT_FREE, 0, 0);
        send_word(pfa_pkg::ACT_COAL, 0, 0);
    endtask

    // Leave fewer free bytes than a header takes, so the room limit saturates.
    task automatic test_small_free_count();
        send_word(pfa_pkg::ACT_INIT, 0, 0);
        send_word(pfa_pkg::ACT_ALLOC, 498, 0);
        send_word(pfa_pkg::ACT_ALLOC, 0, 0);
        send_word(pfa_pkg::ACT_ALLOC, 1, 0);
        send_word(pfa_pkg::ACT_FREE, 0, 503);
    endtask

    // Random action mixes, each run starting from a fresh page.
    task automatic test_random_heap(int n_items, bit no_idle);
        int sent;
        int p;
        calm = no_idle;
        sent = 0;
        while (sent < n_items) begin
            send_word(pfa_pkg::ACT_INIT, $urandom_range(0, 511), $urandom_range(0, 511));
            sent++;
            repeat ($urandom_range(20, 70)) begin
                p = $urandom_range(0, 99);
                if (p < 42)
                    send_word(pfa_pkg::ACT_ALLOC, choose_alloc_size(),
                              $urandom_range(0, 511));
                else if (p < 75)
                    send_word(pfa_pkg::ACT_FREE, $urandom_range(0, 511),
                              choose_free_offset());
                else if (p < 95)
                    send_word(pfa_pkg::ACT_COAL, $urandom_range(0, 511),
                              $urandom_range(0, 511));
                else if (p < 98)
                    send_word(pfa_pkg::ACT_FREE, $urandom_range(0, 511),
                              $urandom_range(0, 511));
                else
                    send_word(pfa_pkg::ACT_INIT, $urandom_range(0, 511),
                              $urandom_range(0, 511));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = pfa_pkg::ACT_INIT;
        calm = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_sent = 0;
        for (int i = 0; i < 4; i++) action_seen[i] = 0;
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        for (int i = 0; i < PAGE; i++) begin
            heap_mark[i] = 1'b0;
            heap_free[i] = 1'b0;
            heap_size[i] = 0;
        end
        heap_free_count = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_before_init();
        test_directed_actions();
        test_small_free_count();
        test_random_heap(350, 1'b1);
        test_random_heap(1470, 1'b0);
        i_s_axis_tvalid = 1'b0;

        // Drain, then watch a while longer for stray output words.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PAGE + 16) @(posedge i_clk);

        $display("Sent %0d words: %0d init, %0d allocate, %0d free, %0d coalesce; checked %0d.",
                 n_sent, action_seen[pfa_pkg::ACT_INIT], action_seen[pfa_pkg::ACT_ALLOC],
                 action_seen[pfa_pkg::ACT_FREE], action_seen[pfa_pkg::ACT_COAL], n_checked);
        $display("Statuses seen: ok %0d, too big %0d, no room %0d, no fit %0d,",
                 status_seen[pfa_pkg::ST_OK], status_seen[pfa_pkg::ST_TOO_BIG],
                 status_seen[pfa_pkg::ST_NO_ROOM], status_seen[pfa_pkg::ST_NO_FIT]);
        $display("  not a header %0d, already free %0d, nothing merged %0d.",
                 status_seen[pfa_pkg::ST_NOT_HDR], status_seen[pfa_pkg::ST_ALREADY],
                 status_seen[pfa_pkg::ST_NO_MERGE]);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
